@@ hdl/csb_pkg.sv @@
// types, codes and character constants shared by the command line serializer
// no dependencies
package csb_pkg;

    localparam logic [2:0] MODE_BEGIN      = 3'd0;
    localparam logic [2:0] MODE_TEXT_ARG   = 3'd1;
    localparam logic [2:0] MODE_TEXT_BYTE  = 3'd2;
    localparam logic [2:0] MODE_DATA_ARG   = 3'd3;
    localparam logic [2:0] MODE_DATA_BYTE  = 3'd4;
    localparam logic [2:0] MODE_END        = 3'd5;

    localparam logic [1:0] STATUS_OK           = 2'd0;
    localparam logic [1:0] STATUS_ALREADY_OPEN = 2'd1;
    localparam logic [1:0] STATUS_NO_ARGUMENT  = 2'd2;

    localparam logic [7:0] CHAR_PAD       = 8'h3D; // '='
    localparam logic [7:0] CHAR_COLON     = 8'h3A; // ':'
    localparam logic [7:0] CHAR_SEMICOLON = 8'h3B; // ';'
    localparam logic [7:0] CHAR_BANG      = 8'h21; // '!'
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C; // '\'
    localparam logic [7:0] CHAR_NULL      = 8'h00;

    localparam int MAX_CHARS = 6;

    // one queued entry: the characters one input item produces
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [2:0]                count;
        logic [1:0]                status;
    } csb_entry_t;

    // standard base64 alphabet
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26)
        begin
            c = 8'h41 + {2'b00, v};
        end
        else if (v < 6'd52)
        begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end
        else if (v < 6'd62)
        begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end
        else if (v == 6'd62)
        begin
            c = 8'h2B;
        end
        else
        begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

@@ hdl/csb_ifs.sv @@
// valid/ready stream interfaces for command items and output characters
// no dependencies
interface csb_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [7:0] in_byte;
    logic       last_data;

    modport source (output valid, output mode, output in_byte, output last_data, input ready);
    modport sink   (input valid, input mode, input in_byte, input last_data, output ready);
endinterface

interface csb_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic [1:0] status;
    logic       run_end;

    modport source (output valid, output out_char, output status, output run_end, input ready);
    modport sink   (input valid, input out_char, input status, input run_end, output ready);
endinterface

@@ hdl/csb_front.sv @@
// front end: accepts command items, tracks command and base64 group state
// and builds the character entry for each item; uses csb_pkg
module csb_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [2:0]          mode,
    input  logic [7:0]          in_byte,
    input  logic                last_data,
    output logic                push,
    output csb_pkg::csb_entry_t entry
);

    logic        has_arg_reg, has_arg_next;
    logic [15:0] group_bytes_reg, group_bytes_next;
    logic [1:0]  group_fill_reg, group_fill_next;

    logic        do_group;
    logic [23:0] gbits;
    logic [1:0]  gfill;
    logic [1:0]  tail_n;
    logic [7:0]  t0, t1;
    logic [1:0]  status;
    logic [7:0]  g0, g1, g2, g3;
    logic        special;

    assign special = (in_byte == csb_pkg::CHAR_COLON) || (in_byte == csb_pkg::CHAR_SEMICOLON)
                  || (in_byte == csb_pkg::CHAR_BANG) || (in_byte == csb_pkg::CHAR_BACKSLASH);

    always_comb
    begin
        has_arg_next     = has_arg_reg;
        group_bytes_next = group_bytes_reg;
        group_fill_next  = group_fill_reg;
        do_group         = 1'b0;
        gbits            = {group_bytes_reg, 8'h00};
        gfill            = group_fill_reg;
        tail_n           = 2'd0;
        t0               = csb_pkg::CHAR_NULL;
        t1               = csb_pkg::CHAR_NULL;
        status           = csb_pkg::STATUS_OK;
        unique case (mode)
            csb_pkg::MODE_BEGIN:
            begin
                if (has_arg_reg)
                begin
                    tail_n = 2'd1;
                    status = csb_pkg::STATUS_ALREADY_OPEN;
                end
                else
                begin
                    do_group         = (group_fill_reg != 2'd0);
                    group_fill_next  = 2'd0;
                    group_bytes_next = 16'h0000;
                    has_arg_next     = 1'b1;
                end
            end
            csb_pkg::MODE_TEXT_ARG, csb_pkg::MODE_DATA_ARG:
            begin
                do_group         = (group_fill_reg != 2'd0);
                group_fill_next  = 2'd0;
                group_bytes_next = 16'h0000;
                has_arg_next     = 1'b1;
                if (has_arg_reg)
                begin
                    t0 = csb_pkg::CHAR_COLON;
                    t1 = csb_pkg::CHAR_BANG;
                    tail_n = (mode == csb_pkg::MODE_DATA_ARG) ? 2'd2 : 2'd1;
                end
                else if (mode == csb_pkg::MODE_DATA_ARG)
                begin
                    t0 = csb_pkg::CHAR_BANG;
                    tail_n = 2'd1;
                end
            end
            csb_pkg::MODE_TEXT_BYTE:
            begin
                if (special)
                begin
                    t0 = csb_pkg::CHAR_BACKSLASH;
                    t1 = in_byte;
                    tail_n = 2'd2;
                end
                else
                begin
                    t0 = in_byte;
                    tail_n = 2'd1;
                end
            end
            csb_pkg::MODE_DATA_BYTE:
            begin
                if (group_fill_reg >= 2'd2)
                begin
                    do_group         = 1'b1;
                    gbits            = {group_bytes_reg, in_byte};
                    gfill            = 2'd3;
                    group_fill_next  = 2'd0;
                    group_bytes_next = 16'h0000;
                end
                else
                begin
                    if (group_fill_reg == 2'd0)
                    begin
                        group_bytes_next = {in_byte, 8'h00};
                    end
                    else
                    begin
                        group_bytes_next = {group_bytes_reg[15:8], in_byte};
                    end
                    if (last_data)
                    begin
                        do_group         = 1'b1;
                        gbits            = {group_bytes_next, 8'h00};
                        gfill            = group_fill_reg + 2'd1;
                        group_fill_next  = 2'd0;
                        group_bytes_next = 16'h0000;
                    end
                    else
                    begin
                        group_fill_next = group_fill_reg + 2'd1;
                    end
                end
            end
            csb_pkg::MODE_END:
            begin
                if (!has_arg_reg)
                begin
                    tail_n = 2'd1;
                    status = csb_pkg::STATUS_NO_ARGUMENT;
                end
                else
                begin
                    do_group         = (group_fill_reg != 2'd0);
                    group_fill_next  = 2'd0;
                    group_bytes_next = 16'h0000;
                    has_arg_next     = 1'b0;
                    t0               = csb_pkg::CHAR_SEMICOLON;
                    tail_n           = 2'd1;
                end
            end
            default:
            begin
                // unused modes leave everything as is
            end
        endcase
    end

    assign g0 = csb_pkg::b64_char(gbits[23:18]);
    assign g1 = csb_pkg::b64_char(gbits[17:12]);
    assign g2 = (gfill >= 2'd2) ? csb_pkg::b64_char(gbits[11:6]) : csb_pkg::CHAR_PAD;
    assign g3 = (gfill == 2'd3) ? csb_pkg::b64_char(gbits[5:0]) : csb_pkg::CHAR_PAD;

    always_comb
    begin
        entry.status = status;
        if (do_group)
        begin
            entry.chars = {t1, t0, g3, g2, g1, g0};
            entry.count = 3'd4 + {1'b0, tail_n};
        end
        else
        begin
            entry.chars = {32'h0, t1, t0};
            entry.count = {1'b0, tail_n};
        end
    end

    assign push = accept && (entry.count != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_arg_reg     <= 1'b0;
            group_bytes_reg <= 16'h0000;
            group_fill_reg  <= 2'd0;
        end
        else if (accept)
        begin
            has_arg_reg     <= has_arg_next;
            group_bytes_reg <= group_bytes_next;
            group_fill_reg  <= group_fill_next;
        end
    end

endmodule

@@ hdl/csb_queue.sv @@
// short entry queue between front and back end
// uses csb_pkg for the entry type
module csb_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  csb_pkg::csb_entry_t push_data,
    input  logic                pop,
    output logic                full,
    output logic                head_valid,
    output csb_pkg::csb_entry_t head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    csb_pkg::csb_entry_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ hdl/csb_back.sv @@
// back end: holds one entry and sends its characters one per cycle while out_ready is high
// uses csb_pkg for the entry type
module csb_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  csb_pkg::csb_entry_t head_data,
    output logic                pop,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [7:0]          out_char,
    output logic [1:0]          status,
    output logic                run_end
);

    logic                busy_reg;
    csb_pkg::csb_entry_t cur_reg;
    logic [2:0]          idx_reg;
    logic                last_char;
    logic                fire;

    assign last_char = ((idx_reg + 3'd1) == cur_reg.count);
    assign fire      = busy_reg && out_ready;
    assign pop       = head_valid && (!busy_reg || (fire && last_char));

    assign out_valid = busy_reg;
    assign out_char  = cur_reg.chars[idx_reg];
    assign status    = cur_reg.status;
    assign run_end   = last_char;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= 3'd0;
        end
        else if (fire)
        begin
            if (last_char)
            begin
                busy_reg <= 1'b0;
                idx_reg  <= 3'd0;
            end
            else
            begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

endmodule

@@ hdl/command_line_serializer_base64_core.sv @@
// Command line serializer with base64 data arguments. A command item is
// taken in every cycle while the entry queue (QUEUE_DEPTH entries) has room;
// the front end turns it at once into zero to six characters (escaped text,
// separators, '!' plus base64 groups with '=' padding, ';' or an error
// result), and the back end sends them one character per cycle while the
// output is ready. An item's entry is registered in the queue and then in
// the back end's holding register before its first character appears;
// run_end marks the last character of each item. Items that produce no
// characters never enter the queue.
// top level; uses csb_pkg, csb_ifs, csb_front, csb_queue and csb_back
module command_line_serializer_base64_core
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    csb_cmd_if.sink     cmd_in,
    csb_char_if.source  char_out
);

    logic                accept;
    logic                push;
    logic                pop;
    logic                full;
    logic                head_valid;
    csb_pkg::csb_entry_t entry;
    csb_pkg::csb_entry_t head_data;

    assign cmd_in.ready = !full;
    assign accept       = cmd_in.valid && !full;

    csb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .mode      (cmd_in.mode),
        .in_byte   (cmd_in.in_byte),
        .last_data (cmd_in.last_data),
        .push      (push),
        .entry     (entry)
    );

    csb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (entry),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    csb_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_ready  (char_out.ready),
        .out_valid  (char_out.valid),
        .out_char   (char_out.out_char),
        .status     (char_out.status),
        .run_end    (char_out.run_end)
    );

endmodule

@@ hdl/csb_checker.sv @@
// port-level checks on the serializer output stream, bound to the top level
// uses csb_pkg status codes
module csb_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic [1:0] status,
    input logic       run_end
);

    // a stalled transaction keeps its valid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped while stalled");

    // a stalled transaction keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_char) && $stable(status) && $stable(run_end))
        else $error("output payload changed while stalled");

    // an error result is a lone null character
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != csb_pkg::STATUS_OK) |-> (out_char == csb_pkg::CHAR_NULL) && run_end)
        else $error("error result malformed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == csb_pkg::STATUS_OK) || (status == csb_pkg::STATUS_ALREADY_OPEN)
                      || (status == csb_pkg::STATUS_NO_ARGUMENT))
        else $error("undefined status code");

endmodule

bind command_line_serializer_base64_core csb_checker u_csb_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (char_out.valid),
    .out_ready (char_out.ready),
    .out_char  (char_out.out_char),
    .status    (char_out.status),
    .run_end   (char_out.run_end)
);

@@ sim/testbench.sv @@
// self-checking testbench for command_line_serializer_base64_core: predicts the
// character stream of every accepted command transaction and checks each output
// depends on csb_pkg, csb_ifs and the serializer rtl
module testbench;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] in_byte;
        logic       last_data;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic [1:0] status;
        logic       run_end;
    } char_result_t;

    localparam logic [8*64-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int ITEMS_PER_PHASE = 30;

    logic clk;
    logic rst_n;

    csb_cmd_if  cmd_bus ();
    csb_char_if char_bus ();

    command_line_serializer_base64_core u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_in   (cmd_bus),
        .char_out (char_bus)
    );

    cmd_item_t    pending_cmds[$];
    char_result_t expected_chars[$];
    char_result_t item_chars[$];
    cmd_item_t    next_cmd;
    char_result_t got_char;
    char_result_t want_char;

    // shadow of the serializer state
    logic        arg_open;
    logic [15:0] group_bytes;
    logic [1:0]  group_fill;

    int send_idle_pct;
    int stall_pct;
    int error_count;
    int queued_count;
    int phase;
    int target;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic logic [7:0] b64_lookup(input logic [5:0] idx);
        return B64_ALPHABET[8*(63-idx) +: 8];
    endfunction

    function void add_char(input logic [7:0] c, input logic [1:0] st);
        item_chars.push_back('{out_char: c, status: st, run_end: 1'b0});
    endfunction

    function void add_group(input logic [23:0] bits, input int fill);
        add_char(b64_lookup(bits[23:18]), csb_pkg::STATUS_OK);
        add_char(b64_lookup(bits[17:12]), csb_pkg::STATUS_OK);
        add_char((fill >= 2) ? b64_lookup(bits[11:6]) : csb_pkg::CHAR_PAD, csb_pkg::STATUS_OK);
        add_char((fill >= 3) ? b64_lookup(bits[5:0]) : csb_pkg::CHAR_PAD, csb_pkg::STATUS_OK);
    endfunction

    function void flush_group();
        if (group_fill != 2'd0)
        begin
            add_group({group_bytes, 8'h00}, int'(group_fill));
            group_fill  = 2'd0;
            group_bytes = 16'h0000;
        end
    endfunction

    function void predict_command(input logic [2:0] mode, input logic [7:0] b,
                                  input logic last);
        item_chars = {};
        case (mode)
            csb_pkg::MODE_BEGIN:
            begin
                if (arg_open)
                begin
                    add_char(csb_pkg::CHAR_NULL, csb_pkg::STATUS_ALREADY_OPEN);
                end
                else
                begin
                    flush_group();
                    arg_open = 1'b1;
                end
            end
            csb_pkg::MODE_TEXT_ARG, csb_pkg::MODE_DATA_ARG:
            begin
                flush_group();
                if (arg_open)
                begin
                    add_char(csb_pkg::CHAR_COLON, csb_pkg::STATUS_OK);
                end
                if (mode == csb_pkg::MODE_DATA_ARG)
                begin
                    add_char(csb_pkg::CHAR_BANG, csb_pkg::STATUS_OK);
                end
                arg_open = 1'b1;
            end
            csb_pkg::MODE_TEXT_BYTE:
            begin
                if (b == csb_pkg::CHAR_COLON || b == csb_pkg::CHAR_SEMICOLON ||
                    b == csb_pkg::CHAR_BANG || b == csb_pkg::CHAR_BACKSLASH)
                begin
                    add_char(csb_pkg::CHAR_BACKSLASH, csb_pkg::STATUS_OK);
                end
                add_char(b, csb_pkg::STATUS_OK);
            end
            csb_pkg::MODE_DATA_BYTE:
            begin
                if (group_fill >= 2'd2)
                begin
                    add_group({group_bytes, b}, 3);
                    group_bytes = 16'h0000;
                    group_fill  = 2'd0;
                end
                else
                begin
                    if (group_fill == 2'd0)
                    begin
                        group_bytes = {b, 8'h00};
                    end
                    else
                    begin
                        group_bytes[7:0] = b;
                    end
                    group_fill = group_fill + 2'd1;
                    if (last)
                    begin
                        flush_group();
                    end
                end
            end
            csb_pkg::MODE_END:
            begin
                if (!arg_open)
                begin
                    add_char(csb_pkg::CHAR_NULL, csb_pkg::STATUS_NO_ARGUMENT);
                end
                else
                begin
                    flush_group();
                    add_char(csb_pkg::CHAR_SEMICOLON, csb_pkg::STATUS_OK);
                    arg_open = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        if (item_chars.size() > 0)
        begin
            item_chars[item_chars.size()-1].run_end = 1'b1;
        end
        foreach (item_chars[i])
        begin
            expected_chars.push_back(item_chars[i]);
        end
    endfunction

    function void queue_cmd(input logic [2:0] m, input logic [7:0] b, input logic l);
        pending_cmds.push_back('{mode: m, in_byte: b, last_data: l});
        queued_count++;
    endfunction

    function automatic logic [7:0] random_text_byte();
        if ($urandom_range(3) != 0)
        begin
            return 8'($urandom_range(255));
        end
        case ($urandom_range(3))
            0: return csb_pkg::CHAR_COLON;
            1: return csb_pkg::CHAR_SEMICOLON;
            2: return csb_pkg::CHAR_BANG;
            default: return csb_pkg::CHAR_BACKSLASH;
        endcase
    endfunction

    // mostly well-formed commands with random content, plus noise and broken framing
    function void queue_random_command();
        int n_name;
        int n_args;
        int n_bytes;
        if ($urandom_range(99) < 15)
        begin
            queue_cmd(3'($urandom_range(7)), 8'($urandom_range(255)), 1'($urandom_range(1)));
            return;
        end
        if ($urandom_range(9) != 0)
        begin
            queue_cmd(csb_pkg::MODE_BEGIN, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        n_name = $urandom_range(3);
        for (int i = 0; i < n_name; i++)
        begin
            queue_cmd(csb_pkg::MODE_TEXT_BYTE, random_text_byte(), 1'($urandom_range(1)));
        end
        n_args = $urandom_range(3);
        for (int a = 0; a < n_args; a++)
        begin
            if ($urandom_range(1) != 0)
            begin
                queue_cmd(csb_pkg::MODE_TEXT_ARG, 8'($urandom_range(255)),
                          1'($urandom_range(1)));
                n_bytes = $urandom_range(4);
                for (int i = 0; i < n_bytes; i++)
                begin
                    queue_cmd(csb_pkg::MODE_TEXT_BYTE, random_text_byte(),
                              1'($urandom_range(1)));
                end
            end
            else
            begin
                queue_cmd(csb_pkg::MODE_DATA_ARG, 8'($urandom_range(255)),
                          1'($urandom_range(1)));
                n_bytes = $urandom_range(7);
                for (int i = 0; i < n_bytes; i++)
                begin
                    // a group left open is closed by the next argument or end transaction
                    queue_cmd(csb_pkg::MODE_DATA_BYTE, 8'($urandom_range(255)),
                              (i == n_bytes - 1) ? 1'($urandom_range(1))
                                                 : 1'($urandom_range(19) == 0));
                end
            end
        end
        if ($urandom_range(9) != 0)
        begin
            queue_cmd(csb_pkg::MODE_END, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endfunction

    task wait_drained();
        while (pending_cmds.size() != 0 || expected_chars.size() != 0 || cmd_bus.valid)
        begin
            @(negedge clk);
        end
    endtask

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_bus.valid     <= 1'b0;
            cmd_bus.mode      <= csb_pkg::MODE_BEGIN;
            cmd_bus.in_byte   <= 8'h00;
            cmd_bus.last_data <= 1'b0;
        end
        else
        begin
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                predict_command(cmd_bus.mode, cmd_bus.in_byte, cmd_bus.last_data);
            end
            if (!cmd_bus.valid || cmd_bus.ready)
            begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_cmd = pending_cmds.pop_front();
                    cmd_bus.valid     <= 1'b1;
                    cmd_bus.mode      <= next_cmd.mode;
                    cmd_bus.in_byte   <= next_cmd.in_byte;
                    cmd_bus.last_data <= next_cmd.last_data;
                end
                else
                begin
                    cmd_bus.valid <= 1'b0;
                end
            end
        end
    end

    // character monitor and backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_bus.ready <= 1'b0;
        end
        else
        begin
            if (char_bus.valid && char_bus.ready)
            begin
                got_char = '{out_char: char_bus.out_char, status: char_bus.status,
                             run_end: char_bus.run_end};
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected character transaction: out_char %h status %0d",
                           got_char.out_char, got_char.status);
                    error_count++;
                end
                else
                begin
                    want_char = expected_chars.pop_front();
                    if (got_char.out_char !== want_char.out_char)
                    begin
                        $error("out_char: expected %h, got %h",
                               want_char.out_char, got_char.out_char);
                        error_count++;
                    end
                    if (got_char.status !== want_char.status)
                    begin
                        $error("status: expected %0d, got %0d",
                               want_char.status, got_char.status);
                        error_count++;
                    end
                    if (got_char.run_end !== want_char.run_end)
                    begin
                        $error("run_end: expected %0d, got %0d",
                               want_char.run_end, got_char.run_end);
                        error_count++;
                    end
                end
            end
            char_bus.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        arg_open          = 1'b0;
        group_bytes       = 16'h0000;
        group_fill        = 2'd0;
        send_idle_pct     = 0;
        stall_pct         = 0;
        error_count       = 0;
        queued_count      = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // end with no command open, then a doubled begin
        queue_cmd(csb_pkg::MODE_END, 8'hFF, 1'b1);
        queue_cmd(csb_pkg::MODE_BEGIN, 8'hFF, 1'b1);
        queue_cmd(csb_pkg::MODE_BEGIN, 8'h00, 1'b0);
        // escaped and plain text bytes at the extremes
        queue_cmd(csb_pkg::MODE_TEXT_BYTE, 8'h00, 1'b0);
        queue_cmd(csb_pkg::MODE_TEXT_BYTE, csb_pkg::CHAR_COLON, 1'b0);
        queue_cmd(csb_pkg::MODE_TEXT_BYTE, csb_pkg::CHAR_SEMICOLON, 1'b0);
        queue_cmd(csb_pkg::MODE_TEXT_BYTE, csb_pkg::CHAR_BANG, 1'b0);
        queue_cmd(csb_pkg::MODE_TEXT_BYTE, csb_pkg::CHAR_BACKSLASH, 1'b0);
        queue_cmd(csb_pkg::MODE_TEXT_BYTE, 8'hFF, 1'b1);
        queue_cmd(csb_pkg::MODE_TEXT_ARG, 8'h00, 1'b0);
        // full group, then one and two byte groups closed by the last flag
        queue_cmd(csb_pkg::MODE_DATA_ARG, 8'h00, 1'b0);
        queue_cmd(csb_pkg::MODE_DATA_BYTE, 8'h00, 1'b0);
        queue_cmd(csb_pkg::MODE_DATA_BYTE, 8'hFF, 1'b0);
        queue_cmd(csb_pkg::MODE_DATA_BYTE, 8'h80, 1'b0);
        queue_cmd(csb_pkg::MODE_DATA_BYTE, 8'hFB, 1'b1);
        queue_cmd(csb_pkg::MODE_DATA_BYTE, 8'hEF, 1'b0);
        queue_cmd(csb_pkg::MODE_DATA_BYTE, 8'hBE, 1'b1);
        // text byte while a group is pending, group closed by the next start
        queue_cmd(csb_pkg::MODE_DATA_BYTE, 8'h12, 1'b0);
        queue_cmd(csb_pkg::MODE_TEXT_BYTE, 8'h41, 1'b0);
        queue_cmd(csb_pkg::MODE_DATA_ARG, 8'hFF, 1'b1);
        queue_cmd(csb_pkg::MODE_DATA_BYTE, 8'h34, 1'b0);
        queue_cmd(csb_pkg::MODE_DATA_BYTE, 8'h56, 1'b0);
        queue_cmd(csb_pkg::MODE_END, 8'h00, 1'b0);
        // data byte outside any command, flushed by begin
        queue_cmd(csb_pkg::MODE_DATA_BYTE, 8'h78, 1'b0);
        queue_cmd(csb_pkg::MODE_BEGIN, 8'h00, 1'b0);
        queue_cmd(3'd6, 8'hAA, 1'b1);
        queue_cmd(3'd7, 8'h55, 1'b0);

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 57; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 57; end
                default: begin send_idle_pct = 20; stall_pct = 20; end
            endcase
            target = queued_count + ITEMS_PER_PHASE;
            while (queued_count < target)
            begin
                queue_random_command();
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (error_count == 0 && expected_chars.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
